FILE: sv/cfmt_pkg.sv
// ----------------------------------------------------------------------------
// cfmt_pkg
// Shared types, codes and helpers of the first-match prefix table.
// ----------------------------------------------------------------------------
package cfmt_pkg;

	localparam int ADDR_W  = 32;
	localparam int PLEN_W  = 6;
	localparam int VALUE_W = 32;

	localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_BAD_PREFIX = 2'd2;

	typedef struct packed {
		logic                       opcode;
		logic [ADDR_W-1:0]          ip_address;
		logic [PLEN_W-1:0]          prefix_length;
		logic signed [VALUE_W-1:0]  entry_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic                       matched;
		logic signed [VALUE_W-1:0]  match_value;
	} rsp_t;

	// classified item between front and back
	typedef struct packed {
		logic                       opcode;
		logic                       bad_prefix;
		logic [ADDR_W-1:0]          ip_address;
		logic [ADDR_W-1:0]          mask;
		logic signed [VALUE_W-1:0]  entry_value;
	} work_t;

	// one table entry, network stored already masked
	typedef struct packed {
		logic [ADDR_W-1:0]          network;
		logic [ADDR_W-1:0]          mask;
		logic signed [VALUE_W-1:0]  value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// left-aligned mask of len ones, len in 0..32
	function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [PLEN_W-1:0] len);
		logic [ADDR_W-1:0] ones;
		ones = '1;
		return ~(ones >> len);
	endfunction

endpackage

FILE: sv/cidr_first_match_table.sv
// ----------------------------------------------------------------------------
// cidr_first_match_table
// Ordered first-match IPv4 prefix table with append and lookup commands.
// ----------------------------------------------------------------------------
// usage
//   command channel: a transfer happens at a clock edge with start high and
//   busy low; cmd carries opcode, address, prefix length and entry value
//   result channel: done is high for one cycle with rsp valid; every command
//   gives exactly one result, in command order; the receiver cannot stall
//   a two-entry queue sits between the command front end and the table
//   engine; busy is high while that queue is full
//   insert: result registered once the engine is free and takes the item
//   lookup: the engine reads entries in insertion order until the first
//   match, or through all entries when none matches, at least one entry;
//   the engine reads one entry per cycle from the table memory, so a full
//   scan of TABLE_DEPTH entries bounds the lookup rate
//   a lookup on an empty table answers like an insert, without a scan
//   reset empties the table and the queue; memory contents are not cleared
//   and entries above the fill count are never read
// ----------------------------------------------------------------------------
module cidr_first_match_table
	import cfmt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	logic  q_valid;
	work_t q_item;
	logic  q_pop;

	cfmt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	cfmt_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.done    (done),
		.rsp     (rsp)
	);

endmodule

FILE: sv/cfmt_ram.sv
// ----------------------------------------------------------------------------
// cfmt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/cfmt_front.sv
// ----------------------------------------------------------------------------
// cfmt_front
// Takes command transfers, checks the prefix length, builds the mask and
// holds classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cfmt_front
	import cfmt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  cmd_t  cmd,
	output logic  q_valid,
	output work_t q_item,
	input  logic  q_pop
);

	work_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	work_t      item_d;

	assign busy    = (fill_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];

	always_comb begin
		item_d.opcode      = cmd.opcode;
		item_d.bad_prefix  = (cmd.prefix_length > PLEN_MAX);
		item_d.ip_address  = cmd.ip_address;
		item_d.mask        = prefix_to_mask(cmd.prefix_length);
		item_d.entry_value = cmd.entry_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/cfmt_back.sv
// ----------------------------------------------------------------------------
// cfmt_back
// Executes queued items: appends entries to the table memory and scans it
// in insertion order, one entry per cycle, for the first matching prefix.
// ----------------------------------------------------------------------------
module cfmt_back
	import cfmt_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  work_t q_item,
	output logic  q_pop,
	output logic  done,
	output rsp_t  rsp
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic              state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [IDX_W-1:0]  chk_q;
	logic [ADDR_W-1:0] addr_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_entry;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	entry_t            rd_entry;
	logic [ENTRY_W-1:0] rd_bits;

	logic              hit;
	logic              last;

	cfmt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_bits)
	);

	assign rd_entry = entry_t'(rd_bits);
	assign hit      = ((addr_q & rd_entry.mask) == rd_entry.network);
	assign last     = ((CNT_W'(chk_q) + CNT_W'(1)) == count_q);

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign wr_addr  = count_q[IDX_W-1:0];

	always_comb begin
		wr_entry.network = q_item.ip_address & q_item.mask;
		wr_entry.mask    = q_item.mask;
		wr_entry.value   = q_item.entry_value;
		wr_en   = q_pop && (q_item.opcode == OP_INSERT) && !q_item.bad_prefix
			&& (count_q != CNT_W'(TABLE_DEPTH));
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop && (q_item.opcode == OP_LOOKUP) && (count_q != '0)) begin
					rd_en = 1'b1;
				end
			end
			S_SCAN: begin
				if (!hit && !last && (idx_q < count_q)) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[IDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			addr_q <= q_item.ip_address;
		end
		if (rd_en) begin
			chk_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (rd_en) begin
				idx_q <= CNT_W'(rd_addr) + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						rsp_q.status      <= ST_OK;
						rsp_q.matched     <= 1'b0;
						rsp_q.match_value <= '0;
						if (q_item.opcode == OP_INSERT) begin
							done_q <= 1'b1;
							if (q_item.bad_prefix) begin
								rsp_q.status <= ST_BAD_PREFIX;
							end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
								rsp_q.status <= ST_FULL;
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						done_q            <= 1'b1;
						rsp_q.status      <= ST_OK;
						rsp_q.matched     <= 1'b1;
						rsp_q.match_value <= rd_entry.value;
						state_q           <= S_IDLE;
					end else if (last) begin
						done_q            <= 1'b1;
						rsp_q.status      <= ST_OK;
						rsp_q.matched     <= 1'b0;
						rsp_q.match_value <= '0;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: sv/cfmt_checker.sv
// ----------------------------------------------------------------------------
// cfmt_checker
// Port-level checks of the prefix table, bound to the top level.
// ----------------------------------------------------------------------------
module cfmt_checker
	import cfmt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	// queue only fills up after a command transfer
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without a command transfer");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_FULL
			|| rsp.status == ST_BAD_PREFIX))
		else $error("illegal result status");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> !rsp.matched && rsp.match_value == '0)
		else $error("rejected insert carries match data");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.matched |-> rsp.match_value == '0)
		else $error("value without a match");

endmodule

bind cidr_first_match_table cfmt_checker u_cfmt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
